/* rtl/core/nsbc_pkg.sv */
`timescale 1ns / 1ps

package nsbc_pkg;

    // token field width is fixed by the interface
    localparam int TOKEN_BITS        = 21;
    localparam int DEF_STACK_DEPTH   = 64;
    localparam int DEF_SIZE_BITS     = 20;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_OPEN  = 3'd1,
        ERR_MISMATCH = 3'd2,
        ERR_CHILDREN = 3'd3,
        ERR_UNCLOSED = 3'd4,
        ERR_OVERFLOW = 3'd5
    } t_err;

    // decision for one token, from the step logic to the stack control
    typedef struct packed {
        logic push;
        logic pop;
        logic wr_below;
        logic set_err;
        t_err err;
    } t_step_ctrl;

endpackage

/* rtl/core/nested_size_bracket_checker.sv */
`timescale 1ns / 1ps
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_token_size, i_has_token, i_end_of_sequence
// output  | o_valid | i_stall | o_valid_res, o_error_kind
//
// one transaction per cycle sustained while the verdict output is not stalled; a verdict
// passes the input register, then the result register, after its sequence's last transaction is accepted
// the innermost container sits in registers and the one below it either in a
// bypass register or in the stack memory's registered read port
// reset clears the stack level, the sticky error and both valid flags
// a stalled verdict holds the input register only if it carries another verdict

module nested_size_bracket_checker #(
    parameter int STACK_DEPTH = nsbc_pkg::DEF_STACK_DEPTH,
    parameter int SIZE_BITS   = nsbc_pkg::DEF_SIZE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [nsbc_pkg::TOKEN_BITS-1:0] i_token_size,
    input  logic                                   i_has_token,
    input  logic                                   i_end_of_sequence,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_valid_res,
    output logic [2:0]                             o_error_kind
);

    import nsbc_pkg::*;

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = 2 * SIZE_BITS + 1;

    // input register
    logic                         r_in_valid;
    logic signed [TOKEN_BITS-1:0] r_in_token;
    logic                         r_in_has;
    logic                         r_in_last;

    // stack state: level, top entry, entry below top (bypass or memory)
    logic [LW-1:0]        r_level, n_level;
    t_err                 r_fail, n_fail;
    logic [SIZE_BITS-1:0] r_top_size, n_top_size;
    logic [SIZE_BITS:0]   r_top_sum, n_top_sum;
    logic [EW-1:0]        r_byp, n_byp;
    logic                 r_sel_mem, n_sel_mem;

    // result register
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_res, n_out_res;
    t_err                 r_out_err, n_out_err;

    logic                 accept;
    logic                 adv;
    logic                 fire;
    t_step_ctrl           ctrl;
    logic [SIZE_BITS-1:0] mag;
    logic [SIZE_BITS:0]   upd_sum;
    logic [EW-1:0]        below;
    logic [EW-1:0]        mem_rdata;
    logic [EW-1:0]        wdata;
    logic                 mem_we;
    logic                 mem_re;
    logic [LW-1:0]        level_after;
    t_err                 kind;

    // the item in the input register may only move on if its verdict has room
    assign adv     = !(r_in_last && r_out_valid && i_stall);
    assign o_stall = r_in_valid && !adv;
    assign accept  = i_valid && !o_stall;
    assign fire    = r_in_valid && adv;

    assign below = r_sel_mem ? mem_rdata : r_byp;
    assign wdata = {r_top_size, upd_sum};

    nsbc_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_token     (r_in_token),
        .i_has_token (r_in_has),
        .i_fail      (r_fail),
        .i_empty     (r_level == '0),
        .i_full      (r_level == LW'(STACK_DEPTH)),
        .i_top_size  (r_top_size),
        .i_top_sum   (r_top_sum),
        .o_ctrl      (ctrl),
        .o_mag       (mag),
        .o_upd_sum   (upd_sum)
    );

    // push spills the old top at level-1; pop refills below from level-3
    assign mem_we = fire && ctrl.wr_below;
    assign mem_re = fire && ctrl.pop && (r_level >= LW'(3));

    nsbc_stack #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (EW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(r_level - LW'(1))),
        .i_wdata (wdata),
        .i_re    (mem_re),
        .i_raddr (AW'(r_level - LW'(3))),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_level     = r_level;
        n_fail      = r_fail;
        n_top_size  = r_top_size;
        n_top_sum   = r_top_sum;
        n_byp       = r_byp;
        n_sel_mem   = r_sel_mem;
        n_out_valid = r_out_valid && i_stall;
        n_out_res   = r_out_res;
        n_out_err   = r_out_err;
        level_after = r_level;
        kind        = r_fail;

        if (fire) begin
            if (ctrl.push) begin
                n_top_size  = mag;
                n_top_sum   = '0;
                level_after = r_level + LW'(1);
                if (ctrl.wr_below) begin
                    n_byp     = wdata;
                    n_sel_mem = 1'b0;
                end
            end
            if (ctrl.pop) begin
                n_top_size  = below[EW-1:SIZE_BITS+1];
                n_top_sum   = below[SIZE_BITS:0];
                n_sel_mem   = 1'b1;
                level_after = r_level - LW'(1);
            end
            if (ctrl.set_err) begin
                kind = ctrl.err;
            end
            n_level = level_after;
            n_fail  = kind;

            // verdict: sticky error, else unclosed if anything is still open
            if (r_in_last) begin
                if (kind == ERR_NONE && level_after != '0) begin
                    kind = ERR_UNCLOSED;
                end
                n_out_valid = 1'b1;
                n_out_res   = (kind == ERR_NONE);
                n_out_err   = kind;
                n_level     = '0;
                n_fail      = ERR_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_level     <= '0;
            r_fail      <= ERR_NONE;
            r_sel_mem   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            r_level     <= n_level;
            r_fail      <= n_fail;
            r_sel_mem   <= n_sel_mem;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_token <= i_token_size;
            r_in_has   <= i_has_token;
            r_in_last  <= i_end_of_sequence;
        end
        r_top_size <= n_top_size;
        r_top_sum  <= n_top_sum;
        r_byp      <= n_byp;
        r_out_res  <= n_out_res;
        r_out_err  <= n_out_err;
    end

    assign o_valid      = r_out_valid;
    assign o_valid_res  = r_out_res;
    assign o_error_kind = r_out_err;

    // stack level never passes the memory depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("stack level above depth");

    // a push that does not end the sequence raises the level by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ctrl.push && !r_in_last) |=> (r_level == $past(r_level) + LW'(1)))
        else $error("push did not raise stack level");

    // a latched error holds until a verdict clears it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail != ERR_NONE && !(fire && r_in_last)) |=> $stable(r_fail))
        else $error("sticky error changed inside a sequence");

    // a delivered verdict is valid exactly when it carries no error
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_res == (r_out_err == ERR_NONE)))
        else $error("verdict flag disagrees with error code");

endmodule

/* rtl/core/nsbc_stack.sv */
`timescale 1ns / 1ps

module nsbc_stack #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 41
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/nsbc_step.sv */
`timescale 1ns / 1ps

module nsbc_step #(
    parameter int SIZE_BITS = 20
) (
    input  logic signed [nsbc_pkg::TOKEN_BITS-1:0] i_token,
    input  logic                                   i_has_token,
    input  nsbc_pkg::t_err                         i_fail,
    input  logic                                   i_empty,
    input  logic                                   i_full,
    input  logic [SIZE_BITS-1:0]                   i_top_size,
    input  logic [SIZE_BITS:0]                     i_top_sum,
    output nsbc_pkg::t_step_ctrl                   o_ctrl,
    output logic [SIZE_BITS-1:0]                   o_mag,
    output logic [SIZE_BITS:0]                     o_upd_sum
);

    import nsbc_pkg::*;

    localparam int W = SIZE_BITS + TOKEN_BITS;

    logic [TOKEN_BITS-1:0] tok_u;
    logic [TOKEN_BITS-1:0] mag_raw;
    logic [W-1:0]          mag_w;
    logic [W-1:0]          max_w;
    logic [W-1:0]          tok_w;
    logic [SIZE_BITS+1:0]  sum_w;
    logic                  live;

    assign tok_u   = i_token;
    assign mag_raw = ~tok_u + 1'b1;
    assign mag_w   = W'(mag_raw);
    assign max_w   = {{TOKEN_BITS{1'b0}}, {SIZE_BITS{1'b1}}};
    assign tok_w   = W'(tok_u);
    assign live    = i_has_token && (i_fail == ERR_NONE);

    // saturate open size, then saturating child sum
    assign o_mag     = (mag_w > max_w) ? {SIZE_BITS{1'b1}} : mag_w[SIZE_BITS-1:0];
    assign sum_w     = {1'b0, i_top_sum} + (SIZE_BITS+2)'(o_mag);
    assign o_upd_sum = sum_w[SIZE_BITS+1] ? {(SIZE_BITS+1){1'b1}} : sum_w[SIZE_BITS:0];

    always_comb begin
        o_ctrl = '{push: 1'b0, pop: 1'b0, wr_below: 1'b0, set_err: 1'b0, err: ERR_NONE};
        if (live) begin
            if (tok_u[TOKEN_BITS-1]) begin
                if (i_full) begin
                    o_ctrl.set_err = 1'b1;
                    o_ctrl.err     = ERR_OVERFLOW;
                end else begin
                    o_ctrl.push     = 1'b1;
                    o_ctrl.wr_below = !i_empty;
                end
            end else if (i_empty) begin
                o_ctrl.set_err = 1'b1;
                o_ctrl.err     = ERR_NO_OPEN;
            end else if (W'(i_top_size) != tok_w) begin
                o_ctrl.set_err = 1'b1;
                o_ctrl.err     = ERR_MISMATCH;
            end else if (W'(i_top_sum) >= tok_w) begin
                o_ctrl.set_err = 1'b1;
                o_ctrl.err     = ERR_CHILDREN;
            end else begin
                o_ctrl.pop = 1'b1;
            end
        end
    end

endmodule

/* verif/nested_size_bracket_checker_tb.sv */
`timescale 1ns / 1ps

module nested_size_bracket_checker_tb;
    import nsbc_pkg::*;

    // block geometry, taken from the package defaults used by the instance
    localparam int TW    = nsbc_pkg::TOKEN_BITS;
    localparam int SW    = nsbc_pkg::DEF_SIZE_BITS;
    localparam int DEPTH = nsbc_pkg::DEF_STACK_DEPTH;

    // cycles with no transaction on either side before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // cycles to wait after the last verdict for anything stray
    localparam int TAIL_CYCLES = 8;

    typedef logic signed [TW-1:0] t_tok;

    localparam t_tok MIN_TOK = {1'b1, {(TW-1){1'b0}}};
    localparam t_tok MAX_TOK = {1'b0, {(TW-1){1'b1}}};
    localparam logic [SW-1:0] SIZE_CAP = '1;
    localparam logic [SW:0]   SUM_CAP  = '1;

    // ways a well-formed sequence gets broken
    typedef enum int {
        FAULT_SIZE,
        FAULT_DROP,
        FAULT_EXTRA_CLOSE,
        FAULT_FLIP,
        FAULT_ZERO_CLOSE,
        FAULT_GARBLE
    } t_fault;
    localparam int FAULT_KINDS = 6;

    typedef struct {
        logic valid_res;
        t_err kind;
    } t_verdict;

    // dut inputs, all known from time zero
    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_valid           = 1'b0;
    logic       o_stall;
    t_tok       i_token_size      = '0;
    logic       i_has_token       = 1'b0;
    logic       i_end_of_sequence = 1'b0;
    logic       o_valid;
    logic       i_stall           = 1'b0;
    logic       o_valid_res;
    logic [2:0] o_error_kind;

    nested_size_bracket_checker u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_token_size      (i_token_size),
        .i_has_token       (i_has_token),
        .i_end_of_sequence (i_end_of_sequence),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_valid_res       (o_valid_res),
        .o_error_kind      (o_error_kind)
    );

    always #5 i_clk = ~i_clk;

    // nesting tracker state, mirrors what the block should hold
    logic [SW-1:0] open_sizes  [DEPTH];
    logic [SW:0]   child_total [DEPTH];
    int            nest_level = 0;
    t_err          nest_err   = ERR_NONE;

    // verdicts predicted but not yet seen, oldest first
    t_verdict pending_verdicts[$];
    t_verdict oldest;

    int n_fail      = 0;
    int tokens_sent = 0;

    // sender pacing
    bit valid_on      = 1'b0;  // shadow of i_valid, updated immediately
    bit sender_idles  = 1'b1;
    int burst_left    = 0;

    // receiver stall pattern
    int stall_pct     = 0;
    int stall_phase   = 0;

    // token sequence under construction
    t_tok seq_tokens[$];

    // ------------------------------------------------------------------
    // nesting tracker: updates state for one accepted transaction and
    // queues the verdict when the transaction ends a sequence
    // ------------------------------------------------------------------
    task automatic track_nesting(input t_tok tok, input logic has, input logic eos);
        logic [TW-1:0] mag_raw;
        logic [SW-1:0] mag;
        logic [SW+1:0] wide;
        int            top;
        t_verdict      v;
        top = nest_level - 1;
        // once an error is latched the rest of the sequence is ignored
        if (has && nest_err == ERR_NONE) begin
            if (tok < 0) begin
                mag_raw = -tok;
                // the most negative token has a magnitude one past the size range
                mag = (mag_raw[TW-1:SW] != '0) ? SIZE_CAP : mag_raw[SW-1:0];
                // parent child sum grows even if the push overflows
                if (nest_level > 0) begin
                    wide = child_total[top] + mag;
                    child_total[top] = (wide > SUM_CAP) ? SUM_CAP : wide[SW:0];
                end
                if (nest_level >= DEPTH) begin
                    nest_err = ERR_OVERFLOW;
                end else begin
                    open_sizes[nest_level]  = mag;
                    child_total[nest_level] = '0;
                    nest_level++;
                end
            end else if (nest_level == 0) begin
                nest_err = ERR_NO_OPEN;
            end else if ({1'b0, open_sizes[top]} != $unsigned(tok)) begin
                nest_err = ERR_MISMATCH;
            end else if (child_total[top] >= $unsigned(tok)) begin
                nest_err = ERR_CHILDREN;
            end else begin
                nest_level--;
            end
        end
        if (eos) begin
            v.kind = nest_err;
            if (v.kind == ERR_NONE && nest_level != 0) v.kind = ERR_UNCLOSED;
            v.valid_res = (v.kind == ERR_NONE);
            pending_verdicts.insert(pending_verdicts.size(), v);
            nest_level = 0;
            nest_err   = ERR_NONE;
        end
    endtask

    function automatic t_tok rand_token();
        return t_tok'($urandom);
    endfunction

    // lower valid at most once per step
    task automatic drop_valid();
        if (valid_on) begin
            i_valid  <= 1'b0;
            valid_on = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // send one transaction; returns in the step of its acceptance, or after
    // a gap when the current burst is over
    // ------------------------------------------------------------------
    task automatic send_item(input t_tok tok, input logic has, input logic eos);
        i_token_size      <= tok;
        i_has_token       <= has;
        i_end_of_sequence <= eos;
        if (!valid_on) begin
            i_valid  <= 1'b1;
            valid_on = 1'b1;
        end
        do @(posedge i_clk); while (o_stall);
        track_nesting(tok, has, eos);
        if (has) tokens_sent++;
        if (sender_idles) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                drop_valid();
                // mostly short gaps, now and then a long one
                repeat (($urandom_range(3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4))
                    @(posedge i_clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    // hold the sender until every verdict in flight has come out
    task automatic wait_drained();
        drop_valid();
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    // push seq_tokens through, with optional ignored items sprinkled in;
    // the sequence ends either on its last token or on a bare end marker
    task automatic send_tokens(input bit end_marker, input bit noisy);
        int n;
        n = seq_tokens.size();
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(9) == 0) send_item(rand_token(), 1'b0, 1'b0);
            send_item(seq_tokens[k], 1'b1, !end_marker && k == n - 1);
        end
        if (end_marker || n == 0) send_item(rand_token(), 1'b0, 1'b1);
    endtask

    // well-formed nesting: every child fits, every close matches
    task automatic build_nested(input int n_opens, input int max_depth);
        int sz [DEPTH];
        int sm [DEPTH];
        int d;
        int opens;
        int rem;
        int c;
        bit can_open;
        seq_tokens.delete();
        d     = 0;
        opens = 0;
        while (opens < n_opens || d > 0) begin
            rem      = (d > 0) ? sz[d-1] - sm[d-1] : 0;
            can_open = opens < n_opens && d < max_depth && (d == 0 || rem >= 2);
            if (can_open && (d == 0 || $urandom_range(99) < 55)) begin
                if (d == 0) begin
                    case ($urandom_range(4))
                        0:       c = $urandom_range(2, 64);
                        1:       c = $urandom_range(65, 4096);
                        2:       c = int'(SIZE_CAP);
                        default: c = $urandom_range(4097, int'(SIZE_CAP));
                    endcase
                end else begin
                    case ($urandom_range(3))
                        0:       c = rem - 1;  // child sum lands one below the size
                        1:       c = $urandom_range(1, rem - 1);
                        default: c = $urandom_range(1, (rem + 2) / 4);
                    endcase
                    sm[d-1] += c;
                end
                sz[d] = c;
                sm[d] = 0;
                d++;
                opens++;
                seq_tokens.insert(seq_tokens.size(), t_tok'(-c));
            end else begin
                seq_tokens.insert(seq_tokens.size(), t_tok'(sz[d-1]));
                d--;
            end
        end
    endtask

    // straight chain of nested opens, each one smaller than its parent,
    // then the matching closes; more than DEPTH levels overflows
    task automatic build_chain(input int levels);
        int base;
        base = $urandom_range(1, 1000);
        seq_tokens.delete();
        for (int k = 0; k < levels; k++)
            seq_tokens.insert(seq_tokens.size(), t_tok'(-(base + levels - 1 - k)));
        for (int k = 0; k < levels; k++)
            seq_tokens.insert(seq_tokens.size(), t_tok'(base + k));
    endtask

    task automatic break_sequence();
        int     idx;
        t_fault f;
        idx = $urandom_range(seq_tokens.size() - 1);
        f   = t_fault'($urandom_range(FAULT_KINDS - 1));
        case (f)
            FAULT_SIZE:        seq_tokens[idx] = seq_tokens[idx] +
                                   (($urandom_range(1) != 0) ? t_tok'(1) : t_tok'(-1));
            FAULT_DROP:        seq_tokens.delete(idx);
            FAULT_EXTRA_CLOSE: seq_tokens.insert(idx, t_tok'($urandom_range(1, 4096)));
            FAULT_FLIP:        seq_tokens[idx] = -seq_tokens[idx];
            FAULT_ZERO_CLOSE:  seq_tokens.insert(idx, t_tok'(0));
            default:           seq_tokens[idx] = rand_token();
        endcase
    endtask

    // ------------------------------------------------------------------
    // verdict checker: compares every accepted verdict with the oldest one
    // predicted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, valid_res=%0b error_kind=%0d",
                         $time, o_valid_res, o_error_kind);
                n_fail++;
            end else begin
                oldest = pending_verdicts.pop_front();
                if (o_valid_res !== oldest.valid_res) begin
                    $display("%0t: valid_res mismatch, expected %0b actual %0b",
                             $time, oldest.valid_res, o_valid_res);
                    n_fail++;
                end
                if (o_error_kind !== 3'(oldest.kind)) begin
                    $display("%0t: error_kind mismatch, expected %0d (%s) actual %0d",
                             $time, oldest.kind, oldest.kind.name(), o_error_kind);
                    n_fail++;
                end
            end
        end
    end

    // receiver stall pattern: the stall rate changes every so often, with
    // phases of no stall at all and phases of heavy backpressure
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 150 == 0) begin
            case ($urandom_range(3))
                0:       stall_pct <= 0;
                1:       stall_pct <= 25;
                2:       stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
        end
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // watchdog: counts cycles in which no transaction moves on either side
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
            $display("nested_size_bracket_checker verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // an empty sequence is valid, also after an ignored item
    task automatic test_empty_sequence();
        send_item(rand_token(), 1'b0, 1'b1);
        send_item(rand_token(), 1'b0, 1'b0);
        send_item(rand_token(), 1'b0, 1'b1);
    endtask

    // most negative token saturates to the largest size, closed by the largest token
    task automatic test_size_extremes();
        send_item(MIN_TOK, 1'b1, 1'b0);
        send_item(MAX_TOK, 1'b1, 1'b1);
    endtask

    // closes with nothing open, zero closes, wrong sizes
    task automatic test_close_errors();
        send_item(t_tok'(5), 1'b1, 1'b1);
        send_item(t_tok'(0), 1'b1, 1'b1);
        send_item(t_tok'(-7), 1'b1, 1'b0);
        send_item(t_tok'(6), 1'b1, 1'b1);
        send_item(t_tok'(-3), 1'b1, 1'b0);
        send_item(t_tok'(0), 1'b1, 1'b1);
    endtask

    // child sum right at the limit, over it, and saturated
    task automatic test_child_limit();
        send_item(t_tok'(-5), 1'b1, 1'b0);
        send_item(t_tok'(-4), 1'b1, 1'b0);
        send_item(t_tok'(4), 1'b1, 1'b0);
        send_item(t_tok'(5), 1'b1, 1'b1);
        send_item(t_tok'(-5), 1'b1, 1'b0);
        send_item(t_tok'(-5), 1'b1, 1'b0);
        send_item(t_tok'(5), 1'b1, 1'b0);
        send_item(t_tok'(5), 1'b1, 1'b1);
        // three max-size children push the parent sum past its ceiling
        send_item(-MAX_TOK, 1'b1, 1'b0);
        repeat (3) begin
            send_item(-MAX_TOK, 1'b1, 1'b0);
            send_item(MAX_TOK, 1'b1, 1'b0);
        end
        send_item(MAX_TOK, 1'b1, 1'b1);
    endtask

    // open left at the end, and an early error that masks what follows
    task automatic test_unclosed_and_sticky();
        send_item(t_tok'(-9), 1'b1, 1'b0);
        send_item(rand_token(), 1'b0, 1'b1);
        send_item(t_tok'(1), 1'b1, 1'b0);
        send_item(rand_token(), 1'b0, 1'b0);
        send_item(t_tok'(-2), 1'b1, 1'b0);
        send_item(t_tok'(2), 1'b1, 1'b1);
    endtask

    // stack exactly full and then one level too deep
    task automatic test_stack_depth();
        build_chain(DEPTH);
        send_tokens(1'b0, 1'b0);
        build_chain(DEPTH + 1);
        send_tokens(1'b1, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // random sequences: mostly well-formed nesting with random sizes, some
    // broken ones, some pure noise and the odd deep chain
    // ------------------------------------------------------------------
    task automatic test_random_sequences(input int n_tokens);
        int  goal;
        int  pick;
        bit  paused;
        goal   = tokens_sent + n_tokens;
        paused = 1'b0;
        while (tokens_sent < goal) begin
            // some sequences run back to back with no gaps
            sender_idles = ($urandom_range(4) != 0);
            pick = $urandom_range(99);
            if (pick < 65) begin
                build_nested($urandom_range(1, 12),
                             ($urandom_range(9) == 0) ? DEPTH : $urandom_range(1, 8));
                send_tokens(1'($urandom_range(1)), 1'b1);
            end else if (pick < 88) begin
                build_nested($urandom_range(1, 10), $urandom_range(1, 6));
                break_sequence();
                send_tokens(1'($urandom_range(1)), 1'b1);
            end else if (pick < 96) begin
                // raw tokens, token flag random
                repeat ($urandom_range(0, 7))
                    send_item(rand_token(), 1'($urandom_range(1)), 1'b0);
                send_item(rand_token(), 1'($urandom_range(1)), 1'b1);
            end else begin
                build_chain($urandom_range(DEPTH - 4, DEPTH + 2));
                send_tokens(1'($urandom_range(1)), 1'b0);
            end
            // hold the sender once midway, and now and then at random
            if ((!paused && tokens_sent >= goal - n_tokens / 2) || $urandom_range(29) == 0) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        sender_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_sequence();
        test_size_extremes();
        test_close_errors();
        test_child_limit();
        test_unclosed_and_sticky();
        test_stack_depth();
        test_random_sequences(460);

        // let everything drain, then watch for strays
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_fail == 0 && pending_verdicts.size() == 0) begin
            $display("nested_size_bracket_checker verification clean");
        end else begin
            $display("nested_size_bracket_checker verification failed");
        end
        $finish;
    end

endmodule
